// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the k-ary search block.
// No dependencies; the assertions drop out of synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/core/kss_pkg.sv =====
// Package for the k-ary search block: sizes, control and status structs,
// and the reciprocal table used for the step division. No dependencies.
package kss_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int MAX_ARITY   = 8;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  // Range bounds run from -1 up to TABLE_DEPTH, so two bits over the index.
  localparam int PTR_W       = IDX_W + 2;
  localparam int CNT_W       = 11;
  localparam int ARITY_W     = 4;
  localparam int J_W         = $clog2(MAX_ARITY);
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 16;
  localparam int PROD_W      = IDX_W + RECIP_SHIFT;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [ARITY_W-1:0] ARITY_MIN = ARITY_W'(2);
  localparam logic [ARITY_W-1:0] ARITY_MAX = ARITY_W'(MAX_ARITY);
  localparam logic signed [PTR_W-1:0] PTR_ONE = PTR_W'(1);

  // Register map, by word index.
  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_ARITY   = 1'b1;

  // Input word function codes.
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef struct packed {
    logic init;        // load bounds and key for a new search
    logic mul;         // form (hi-lo) * reciprocal of arity
    logic probe_start; // latch step, first probe = lo + step
    logic probe_next;  // advance to the next probe
    logic hi_probe;    // hi = probe - 1
    logic lo_probe;    // lo = probe + 1
    logic between;     // lo = previous probe + 1, hi = probe - 1
    logic hi_mid;      // hi = mid - 1
    logic lo_mid;      // lo = mid + 1
    logic sel_mid;     // read address from mid rather than probe
  } kss_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic step_zero;
    logic eq;
    logic gt;
    logic lt;
    logic first;
    logic last;
    logic prev_lt;
  } kss_sts_t;

  // ceil(2^RECIP_SHIFT / k); exact floor for dividends below TABLE_DEPTH.
  function automatic logic [RECIP_W-1:0] recip(input logic [ARITY_W-1:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      4'd2:    r = 16'd32768;
      4'd3:    r = 16'd21846;
      4'd4:    r = 16'd16384;
      4'd5:    r = 16'd13108;
      4'd6:    r = 16'd10923;
      4'd7:    r = 16'd9363;
      4'd8:    r = 16'd8192;
      default: r = 16'd32768;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/kss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/kss_dpath.sv =====
// Datapath of the k-ary search: bounds, step, probe pointer and compare.
// Depends on kss_pkg.
module kss_dpath (
  input  logic                          clk,
  input  kss_pkg::kss_cmd_t             cmd,
  output kss_pkg::kss_sts_t             sts,
  input  logic [kss_pkg::CNT_W-1:0]     entries_in_use,
  input  logic [kss_pkg::ARITY_W-1:0]   arity,
  input  logic [kss_pkg::DATA_W-1:0]    search_key,
  input  logic [kss_pkg::DATA_W-1:0]    rdata,
  output logic [kss_pkg::IDX_W-1:0]     raddr
);
  import kss_pkg::*;

  logic signed [PTR_W-1:0]  lo;
  logic signed [PTR_W-1:0]  hi;
  logic signed [PTR_W-1:0]  probe;
  logic signed [PTR_W-1:0]  prev_probe;
  logic signed [DATA_W-1:0] key;
  logic [PROD_W-1:0]        prod;
  logic [IDX_W-1:0]         step;
  logic [J_W-1:0]           j;
  logic                     prev_lt;

  logic [CNT_W-1:0]         n;
  logic [ARITY_W-1:0]       kk;
  logic signed [PTR_W-1:0]  diff;
  logic signed [PTR_W-1:0]  mid;
  logic [IDX_W-1:0]         step_c;
  logic signed [DATA_W-1:0] v;

  // Clamp the count to the table and the arity to its legal range.
  assign n  = (entries_in_use > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_in_use;
  assign kk = (arity < ARITY_MIN) ? ARITY_MIN : ((arity > ARITY_MAX) ? ARITY_MAX : arity);

  assign diff   = hi - lo;
  assign mid    = lo + (diff >>> 1);
  assign step_c = prod[PROD_W-1 -: IDX_W];
  assign v      = $signed(rdata);

  assign raddr = cmd.sel_mid ? mid[IDX_W-1:0] : probe[IDX_W-1:0];

  assign sts.range_ok  = (lo <= hi);
  assign sts.step_zero = (step_c == '0);
  assign sts.eq        = (v == key);
  assign sts.gt        = (v > key);
  assign sts.lt        = (v < key);
  assign sts.first     = (j == '0);
  assign sts.last      = (j == J_W'(kk - ARITY_MIN));
  assign sts.prev_lt   = prev_lt;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      lo  <= '0;
      hi  <= PTR_W'(n) - PTR_ONE;
      key <= $signed(search_key);
    end
    if (cmd.mul) begin
      prod <= PROD_W'(diff[IDX_W-1:0]) * PROD_W'(recip(kk));
    end
    if (cmd.probe_start) begin
      step    <= step_c;
      probe   <= lo + PTR_W'(step_c);
      j       <= '0;
      prev_lt <= 1'b0;
    end
    if (cmd.probe_next) begin
      prev_probe <= probe;
      probe      <= probe + PTR_W'(step);
      j          <= j + J_W'(1);
      prev_lt    <= sts.lt;
    end
    if (cmd.hi_probe) begin
      hi <= probe - PTR_ONE;
    end
    if (cmd.lo_probe) begin
      lo <= probe + PTR_ONE;
    end
    if (cmd.between) begin
      lo <= prev_probe + PTR_ONE;
      hi <= probe - PTR_ONE;
    end
    if (cmd.hi_mid) begin
      hi <= mid - PTR_ONE;
    end
    if (cmd.lo_mid) begin
      lo <= mid + PTR_ONE;
    end
  end

endmodule

// ===== rtl/core/kss_ctrl.sv =====
// Controller of the k-ary search: one-hot sequencer over rounds and probes,
// with the binary fallback. Depends on kss_pkg.
module kss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  output logic              busy,
  output logic              done,
  output logic              found,
  output logic              wr_en,
  output kss_pkg::kss_cmd_t cmd,
  input  kss_pkg::kss_sts_t sts
);
  import kss_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ROUND = 8'b0000_0010,
    S_STEP  = 8'b0000_0100,
    S_PREAD = 8'b0000_1000,
    S_PCMP  = 8'b0001_0000,
    S_BIN   = 8'b0010_0000,
    S_BCMP  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } kss_state_t;

  kss_state_t state;
  kss_state_t state_next;
  logic       found_next;

  assign busy  = (state != S_IDLE);
  assign done  = (state == S_DONE);
  assign wr_en = start && !busy && (func == FUNC_WRITE);

  always_comb begin
    state_next = state;
    found_next = found;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start && (func == FUNC_SEARCH)) begin
          cmd.init   = 1'b1;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (!sts.range_ok) begin
          found_next = 1'b0;
          state_next = S_DONE;
        end else begin
          cmd.mul    = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (sts.step_zero) begin
          state_next = S_BIN;
        end else begin
          cmd.probe_start = 1'b1;
          state_next      = S_PREAD;
        end
      end
      S_PREAD: begin
        state_next = S_PCMP;
      end
      S_PCMP: begin
        if (!sts.first && sts.prev_lt && sts.gt) begin
          cmd.between = 1'b1;
          state_next  = S_ROUND;
        end else if (sts.eq) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else if (sts.first && sts.gt) begin
          cmd.hi_probe = 1'b1;
          state_next   = S_ROUND;
        end else if (sts.last && sts.lt) begin
          cmd.lo_probe = 1'b1;
          state_next   = S_ROUND;
        end else if (sts.last) begin
          found_next = 1'b0;
          state_next = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_PREAD;
        end
      end
      S_BIN: begin
        cmd.sel_mid = 1'b1;
        if (!sts.range_ok) begin
          found_next = 1'b0;
          state_next = S_DONE;
        end else begin
          state_next = S_BCMP;
        end
      end
      S_BCMP: begin
        if (sts.eq) begin
          found_next = 1'b1;
          state_next = S_DONE;
        end else if (sts.gt) begin
          cmd.hi_mid = 1'b1;
          state_next = S_BIN;
        end else begin
          cmd.lo_mid = 1'b1;
          state_next = S_BIN;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

endmodule

// ===== rtl/core/kary_search_sorted_table.sv =====
// Top level of the k-ary search over a sorted table: register port, table RAM,
// controller and datapath. Depends on kss_pkg, kss_ram, kss_ctrl, kss_dpath.
//
//  channel   handshake                      word
//  --------  -----------------------------  ---------------------------------------
//  input     start high, busy low           func, entry_index, entry_value, search_key
//  result    done high for one cycle        found
//  config    psel, penable, pwrite, pready  paddr, pwdata (prdata on reads)
//
// A write word stores one entry in the cycle it is taken and gives no result;
// busy stays low, so words may follow back to back.
// A search runs rounds of a range check with multiply and a step test, plus a
// read and a compare per probe through the single read port of the table RAM,
// then binary steps of a read and a compare; done rises in the cycle after the decision.
// A hit ends the search at the compare that finds it.
// Reset clears the sequencer and the registers (entries_in_use 0, arity 2);
// table contents stay undefined until written.
// The receiver cannot stall: found is valid only in the cycle done is high.
`include "assert_macros.svh"
module kary_search_sorted_table (
  input  logic                          clk,
  input  logic                          rst,
  // input words
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [kss_pkg::IDX_W-1:0]     entry_index,
  input  logic [kss_pkg::DATA_W-1:0]    entry_value,
  input  logic [kss_pkg::DATA_W-1:0]    search_key,
  // result words
  output logic                          done,
  output logic                          found,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kss_pkg::PADDR_W-1:0]   paddr,
  input  logic [kss_pkg::PDATA_W-1:0]   pwdata,
  output logic [kss_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import kss_pkg::*;

  logic [CNT_W-1:0]   entries_in_use;
  logic [ARITY_W-1:0] arity;
  logic               cfg_wr;
  logic               wr_en;
  logic [IDX_W-1:0]   raddr;
  logic [DATA_W-1:0]  rdata;
  kss_cmd_t           cmd;
  kss_sts_t           sts;

  // Register port: no wait states; decode on the word index bit alone.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      arity          <= ARITY_MIN;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ENTRIES) begin
        entries_in_use <= pwdata[CNT_W-1:0];
      end else begin
        arity <= pwdata[ARITY_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_ARITY) ? PDATA_W'(arity) : PDATA_W'(entries_in_use);

  // Table store: writes come straight from accepted write words.
  kss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (entry_index),
    .wdata (entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer: decides each step from the compare status.
  kss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .busy  (busy),
    .done  (done),
    .found (found),
    .wr_en (wr_en),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Bounds, step and probe arithmetic.
  kss_dpath u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .entries_in_use (entries_in_use),
    .arity          (arity),
    .search_key     (search_key),
    .rdata          (rdata),
    .raddr          (raddr)
  );

  // A taken search word must hold the block busy in the next cycle.
  `ASSERT_AT(a_search_holds_busy, clk, rst, (start && !busy && func) |=> busy, "search word dropped")
  // A write word never yields a result.
  `ASSERT_AT(a_write_no_result, clk, rst, (start && !busy && !func) |=> !done, "write gave a result")
  // A result lasts one cycle and frees the block.
  `ASSERT_AT(a_result_single, clk, rst, done |=> (!done && !busy), "result not single-cycle")
  // A table write never lands while a search is running.
  `ASSERT_NEVER(a_no_write_in_search, clk, rst, wr_en && busy, "table written mid-search")

endmodule
